/* sv/dcf_pkg.sv */
`default_nettype none
package dcf_pkg;

  localparam int unsigned DEPTH     = 16;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned IDX_W     = $clog2(DEPTH);
  localparam int unsigned CNT_W     = $clog2(DEPTH + 1);
  localparam int unsigned TALLY_W   = 16;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned LEN_W     = 5;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_W     = LEN_W;

  localparam logic [TALLY_W-1:0] TALLY_MAX = {TALLY_W{1'b1}};
  localparam logic [LEN_W-1:0]   LEN_RESET = LEN_W'(DEPTH);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHANNEL_KIND = 1'd0,
    REG_FIFO_LENGTH  = 1'd1
  } reg_idx_e;

  typedef enum logic [1:0] {
    MODE_WRITE         = 2'd0,
    MODE_READ          = 2'd1,
    MODE_CONSUMER_GONE = 2'd2,
    MODE_PRODUCER_GONE = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    ST_WRITTEN     = 4'd0,
    ST_OVERWROTE   = 4'd1,
    ST_READ        = 4'd2,
    ST_REPEATED    = 4'd3,
    ST_FULL        = 4'd4,
    ST_EMPTY       = 4'd5,
    ST_NO_DEFAULT  = 4'd6,
    ST_PARTNER_GONE = 4'd7,
    ST_MARKED      = 4'd8
  } status_e;

  typedef struct packed {
    logic [1:0]        mode;
    logic [DATA_W-1:0] data;
    logic              no_backup;
  } item_t;

  typedef struct packed {
    logic [3:0]         status;
    logic [DATA_W-1:0]  read_data;
    logic [CNT_W-1:0]   fill_count;
    logic [TALLY_W-1:0] overwrite_run;
  } result_t;

  typedef struct packed {
    logic                 we;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     data;
  } cfg_wr_t;

endpackage
`default_nettype wire

/* sv/dcf_in_if.sv */
`default_nettype none
interface dcf_in_if;
  import dcf_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        mode;
  logic [DATA_W-1:0] data;
  logic              no_backup;

  modport source (output valid, output mode, output data, output no_backup, input ready);
  modport sink   (input valid, input mode, input data, input no_backup, output ready);
endinterface
`default_nettype wire

/* sv/dcf_res_if.sv */
`default_nettype none
interface dcf_res_if;
  import dcf_pkg::*;

  logic               valid;
  logic               ready;
  logic [3:0]         status;
  logic [DATA_W-1:0]  read_data;
  logic [CNT_W-1:0]   fill_count;
  logic [TALLY_W-1:0] overwrite_run;

  modport source (output valid, output status, output read_data, output fill_count,
                  output overwrite_run, input ready);
  modport sink   (input valid, input status, input read_data, input fill_count,
                  input overwrite_run, output ready);
endinterface
`default_nettype wire

/* sv/decoupled_channel_fifo_top.sv */
// channel   dir   signals
// in_i      in    valid ready mode data no_backup
// res_o     out   valid ready status read_data fill_count overwrite_run
// cfg       in    cfg_we_i cfg_idx_i cfg_data_i
//
// one word per cycle sustained while res_o.ready is high; a word is registered in the
// input register, then its result is registered in the result register
// the queue update is one pointer and count step in dcf_core
// reset clears pointers, count, kept copy, tally and marks; slot contents are not cleared
// a stalled result holds the input register; in_i.ready stays high while either stage moves
`default_nettype none
module decoupled_channel_fifo_top
  import dcf_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  dcf_in_if.sink                    in_i,
  dcf_res_if.source                 res_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i
);

  logic    in_vld_q;
  item_t   item_q;
  logic    res_vld_q;
  result_t res_q;
  result_t core_res;
  logic    adv;
  cfg_wr_t cfg;

  assign cfg.we   = cfg_we_i;
  assign cfg.idx  = cfg_idx_i;
  assign cfg.data = cfg_data_i;

  assign adv        = in_vld_q && (!res_vld_q || res_o.ready);
  assign in_i.ready = !in_vld_q || adv;

  dcf_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .fire_i (adv),
    .item_i (item_q),
    .res_o  (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      if (in_i.valid && in_i.ready) begin
        in_vld_q <= 1'b1;
      end else if (adv) begin
        in_vld_q <= 1'b0;
      end
      if (adv) begin
        res_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q.mode      <= in_i.mode;
      item_q.data      <= in_i.data;
      item_q.no_backup <= in_i.no_backup;
    end
    if (adv) begin
      res_q <= core_res;
    end
  end

  assign res_o.valid         = res_vld_q;
  assign res_o.status        = res_q.status;
  assign res_o.read_data     = res_q.read_data;
  assign res_o.fill_count    = res_q.fill_count;
  assign res_o.overwrite_run = res_q.overwrite_run;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && res_vld_q && !res_o.ready) |-> !in_i.ready)
    else $error("input taken while both stages are stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> res_vld_q)
    else $error("processed word produced no result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_q && !res_o.ready && !adv) |=> $stable(res_q))
    else $error("stalled result changed");

endmodule
`default_nettype wire

/* sv/dcf_core.sv */
`default_nettype none
module dcf_core
  import dcf_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire cfg_wr_t cfg_i,
  input  wire logic    fire_i,
  input  wire item_t   item_i,
  output result_t      res_o
);

  logic [DATA_W-1:0]  slots_q [DEPTH];
  logic               slot_nb_q [DEPTH];

  logic [IDX_W-1:0]   rd_idx_q, rd_idx_d;
  logic [IDX_W-1:0]   wr_idx_q, wr_idx_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [DATA_W-1:0]  kept_q, kept_d;
  logic               kept_vld_q, kept_vld_d;
  logic [TALLY_W-1:0] tally_q, tally_d;
  logic               cons_gone_q, cons_gone_d;
  logic               prod_gone_q, prod_gone_d;
  logic [KIND_W-1:0]  kind_q;
  logic [LEN_W-1:0]   flen_q;

  logic [CNT_W-1:0]   len;
  logic               slot_we;
  logic [IDX_W-1:0]   slot_waddr;
  logic [IDX_W-1:0]   ovw_idx;
  logic [IDX_W-1:0]   wr_next;
  logic [IDX_W-1:0]   rd_next;
  logic               len_wr;
  status_e            status;
  logic [DATA_W-1:0]  rdata;

  // effective length, clamped to one..depth
  always_comb begin
    if (flen_q == '0) begin
      len = CNT_W'(1);
    end else if (flen_q > LEN_W'(DEPTH)) begin
      len = CNT_W'(DEPTH);
    end else begin
      len = CNT_W'(flen_q);
    end
  end

  assign wr_next = ((CNT_W'(wr_idx_q) + CNT_W'(1)) >= len) ? '0 : wr_idx_q + IDX_W'(1);
  assign rd_next = ((CNT_W'(rd_idx_q) + CNT_W'(1)) >= len) ? '0 : rd_idx_q + IDX_W'(1);
  assign ovw_idx = (wr_idx_q == '0) ? IDX_W'(len - CNT_W'(1)) : wr_idx_q - IDX_W'(1);
  assign len_wr  = cfg_i.we && (cfg_i.idx == REG_FIFO_LENGTH);

  always_comb begin
    rd_idx_d    = rd_idx_q;
    wr_idx_d    = wr_idx_q;
    cnt_d       = cnt_q;
    kept_d      = kept_q;
    kept_vld_d  = kept_vld_q;
    tally_d     = tally_q;
    cons_gone_d = cons_gone_q;
    prod_gone_d = prod_gone_q;
    slot_we     = 1'b0;
    slot_waddr  = wr_idx_q;
    status      = ST_WRITTEN;
    rdata       = '0;
    unique case (mode_e'(item_i.mode))
      MODE_WRITE: begin
        if (cons_gone_q) begin
          status = ST_PARTNER_GONE;
        end else if (cnt_q < len) begin
          slot_we    = 1'b1;
          slot_waddr = wr_idx_q;
          wr_idx_d   = wr_next;
          cnt_d      = cnt_q + CNT_W'(1);
          tally_d    = '0;
          status     = ST_WRITTEN;
        end else if (kind_q[0]) begin
          slot_we    = 1'b1;
          slot_waddr = ovw_idx;
          if (tally_q != TALLY_MAX) begin
            tally_d = tally_q + TALLY_W'(1);
          end
          status = ST_OVERWROTE;
        end else begin
          status = ST_FULL;
        end
      end
      MODE_READ: begin
        if (cnt_q != '0) begin
          rdata = slots_q[rd_idx_q];
          if (kind_q[1] && (cnt_q == CNT_W'(1)) && !slot_nb_q[rd_idx_q]) begin
            kept_d     = slots_q[rd_idx_q];
            kept_vld_d = 1'b1;
          end
          rd_idx_d = rd_next;
          cnt_d    = cnt_q - CNT_W'(1);
          status   = ST_READ;
        end else if (kind_q[1]) begin
          if (kept_vld_q) begin
            rdata  = kept_q;
            status = ST_REPEATED;
          end else begin
            status = ST_NO_DEFAULT;
          end
        end else begin
          status = prod_gone_q ? ST_PARTNER_GONE : ST_EMPTY;
        end
      end
      MODE_CONSUMER_GONE: begin
        cons_gone_d = 1'b1;
        status      = ST_MARKED;
      end
      MODE_PRODUCER_GONE: begin
        prod_gone_d = 1'b1;
        status      = ST_MARKED;
      end
      default: begin
        status = ST_MARKED;
      end
    endcase
  end

  assign res_o.status        = status;
  assign res_o.read_data     = rdata;
  assign res_o.fill_count    = cnt_d;
  assign res_o.overwrite_run = tally_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q    <= '0;
      wr_idx_q    <= '0;
      cnt_q       <= '0;
      kept_q      <= '0;
      kept_vld_q  <= 1'b0;
      tally_q     <= '0;
      cons_gone_q <= 1'b0;
      prod_gone_q <= 1'b0;
      kind_q      <= '0;
      flen_q      <= LEN_RESET;
    end else begin
      if (len_wr) begin
        rd_idx_q <= '0;
        wr_idx_q <= '0;
        cnt_q    <= '0;
        flen_q   <= cfg_i.data;
      end else if (fire_i) begin
        rd_idx_q <= rd_idx_d;
        wr_idx_q <= wr_idx_d;
        cnt_q    <= cnt_d;
      end
      if (cfg_i.we && (cfg_i.idx == REG_CHANNEL_KIND)) begin
        kind_q <= cfg_i.data[KIND_W-1:0];
      end
      if (fire_i) begin
        kept_q      <= kept_d;
        kept_vld_q  <= kept_vld_d;
        tally_q     <= tally_d;
        cons_gone_q <= cons_gone_d;
        prod_gone_q <= prod_gone_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i && slot_we) begin
      slots_q[slot_waddr]   <= item_i.data;
      slot_nb_q[slot_waddr] <= item_i.no_backup;
    end
  end

  // an empty queue has both pointers on the same slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (rd_idx_q == wr_idx_q))
    else $error("empty queue with pointers apart");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && !len_wr && slot_we && (slot_waddr == wr_idx_q) && (cnt_q < len))
    |=> (cnt_q == $past(cnt_q) + CNT_W'(1)) && (tally_q == '0))
    else $error("normal write did not advance count or clear tally");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && (status == ST_REPEATED)) |-> (kept_vld_q && (cnt_q == '0)))
    else $error("repeat without kept copy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= len)
    else $error("count above queue length");

endmodule
`default_nettype wire

/* bench/tb_decoupled_channel_fifo_top.sv */
`default_nettype none
module tb_decoupled_channel_fifo_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dcf_pkg::*;

  localparam logic [KIND_W-1:0] KIND_BLOCKING  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DEC_WRITE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DEC_READ  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_DEC_BOTH  = 2'd3;

  localparam int unsigned NUM_PHASES   = 12;
  localparam int unsigned PHASE_ITEMS  = 140;
  localparam int unsigned BURST_ITEMS  = 40;
  localparam int unsigned HOLD_CYCLES  = 80;
  localparam int unsigned CYCLE_LIMIT  = 1500000;

  localparam logic [LEN_W-1:0] PHASE_LEN [NUM_PHASES] = '{
    5'd1, 5'd16, 5'd0, 5'd31, 5'd2, 5'd16, 5'd5, 5'd17, 5'd3, 5'd8, 5'd1, 5'd4
  };

  class fifo_scoreboard;
    logic [DATA_W-1:0] slot_word [DEPTH];
    logic              slot_nb   [DEPTH];
    int unsigned       rd_ptr;
    int unsigned       wr_ptr;
    int unsigned       held;
    int unsigned       tally;
    logic [DATA_W-1:0] kept_word;
    bit                kept_ok;
    bit                cons_gone;
    bit                prod_gone;
    logic [KIND_W-1:0] kind;
    logic [LEN_W-1:0]  len_reg;
    result_t           due_q [$];
    int unsigned       errors;

    function new();
      rd_ptr    = 0;
      wr_ptr    = 0;
      held      = 0;
      tally     = 0;
      kept_word = '0;
      kept_ok   = 1'b0;
      cons_gone = 1'b0;
      prod_gone = 1'b0;
      kind      = KIND_BLOCKING;
      len_reg   = LEN_RESET;
      errors    = 0;
    endfunction

    function int unsigned span();
      int unsigned n;
      n = len_reg;
      if (n < 1) n = 1;
      if (n > DEPTH) n = DEPTH;
      return n;
    endfunction

    function int unsigned step_ptr(int unsigned i, int unsigned n);
      return (i + 1 >= n) ? 0 : i + 1;
    endfunction

    function void write_reg(reg_idx_e idx, logic [CFG_W-1:0] v);
      if (idx == REG_CHANNEL_KIND) begin
        kind = v[KIND_W-1:0];
      end else begin
        len_reg = v[LEN_W-1:0];
        rd_ptr  = 0;
        wr_ptr  = 0;
        held    = 0;
      end
    endfunction

    function void note_input(item_t w);
      int unsigned n;
      int unsigned p;
      result_t r;
      n = span();
      r.status    = ST_WRITTEN;
      r.read_data = '0;
      case (mode_e'(w.mode))
        MODE_WRITE: begin
          if (cons_gone) begin
            r.status = ST_PARTNER_GONE;
          end else if (held < n) begin
            p = wr_ptr % DEPTH;
            slot_word[p] = w.data;
            slot_nb[p]   = w.no_backup;
            wr_ptr = step_ptr(p, n);
            held++;
            tally = 0;
          end else if ((kind & KIND_DEC_WRITE) != 0) begin
            p = ((wr_ptr == 0 ? n : wr_ptr) - 1) % DEPTH;
            slot_word[p] = w.data;
            slot_nb[p]   = w.no_backup;
            if (tally < TALLY_MAX) tally++;
            r.status = ST_OVERWROTE;
          end else begin
            r.status = ST_FULL;
          end
        end
        MODE_READ: begin
          if (held > 0) begin
            p = rd_ptr % DEPTH;
            r.read_data = slot_word[p];
            if ((kind & KIND_DEC_READ) != 0 && held == 1 && !slot_nb[p]) begin
              kept_word = slot_word[p];
              kept_ok   = 1'b1;
            end
            rd_ptr = step_ptr(p, n);
            held--;
            r.status = ST_READ;
          end else if ((kind & KIND_DEC_READ) != 0) begin
            if (kept_ok) begin
              r.read_data = kept_word;
              r.status    = ST_REPEATED;
            end else begin
              r.status = ST_NO_DEFAULT;
            end
          end else begin
            r.status = prod_gone ? ST_PARTNER_GONE : ST_EMPTY;
          end
        end
        MODE_CONSUMER_GONE: begin
          cons_gone = 1'b1;
          r.status  = ST_MARKED;
        end
        default: begin
          prod_gone = 1'b1;
          r.status  = ST_MARKED;
        end
      endcase
      r.fill_count    = CNT_W'(held);
      r.overwrite_run = TALLY_W'(tally);
      due_q.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (due_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: unexpected result word status %0d data %h fill %0d run %0d",
                   $time, got.status, got.read_data, got.fill_count, got.overwrite_run);
        return;
      end
      want = due_q.pop_front();
      if (got.status !== want.status || got.read_data !== want.read_data ||
          got.fill_count !== want.fill_count || got.overwrite_run !== want.overwrite_run) begin
        errors++;
        if (errors <= 10)
          $display("%0t: bad result word exp status %0d data %h fill %0d run %0d, got %0d %h %0d %0d",
                   $time, want.status, want.read_data, want.fill_count, want.overwrite_run,
                   got.status, got.read_data, got.fill_count, got.overwrite_run);
      end
    endfunction

    function int unsigned pending();
      return due_q.size();
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  dcf_in_if  in_if ();
  dcf_res_if res_if ();

  decoupled_channel_fifo_top DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .res_o      (res_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  fifo_scoreboard book;
  bit             send_idle;
  bit             recv_idle;
  int unsigned    hold_request;

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  function automatic item_t pick_word(mode_e m);
    item_t w;
    w.mode = m;
    case ($urandom_range(0, 7))
      0:       w.data = '0;
      1:       w.data = '1;
      default: w.data = $urandom;
    endcase
    w.no_backup = ($urandom_range(0, 2) == 0);
    return w;
  endfunction

  task automatic send_word(item_t w);
    int unsigned gap;
    bit took;
    gap = send_idle ? $urandom_range(0, 15) : 0;
    repeat (gap) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.mode      <= w.mode;
    in_if.data      <= w.data;
    in_if.no_backup <= w.no_backup;
    took = 1'b0;
    while (!took) begin
      @(negedge clk_i);
      took = in_if.ready;
      if (took) book.note_input(w);
      @(posedge clk_i);
    end
  endtask

  task automatic put(mode_e m, logic [DATA_W-1:0] d, logic nb);
    item_t w;
    w.mode      = m;
    w.data      = d;
    w.no_backup = nb;
    send_word(w);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (book.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_reg(reg_idx_e idx, logic [CFG_W-1:0] v);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    book.write_reg(idx, v);
  endtask

  task automatic random_run(int unsigned count, bit allow_consumer_mark);
    bit filling;
    int unsigned roll;
    mode_e m;
    filling = 1'b1;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 23) == 0) filling = !filling;
      roll = $urandom_range(0, 99);
      if (roll < 2) m = MODE_PRODUCER_GONE;
      else if (allow_consumer_mark && roll < 4) m = MODE_CONSUMER_GONE;
      else if (roll < (filling ? 87 : 27)) m = MODE_WRITE;
      else m = MODE_READ;
      send_word(pick_word(m));
    end
  endtask

  initial begin : result_side
    int unsigned stall;
    int unsigned hold_left;
    result_t got;
    stall     = 0;
    hold_left = 0;
    res_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        res_if.ready <= 1'b0;
        hold_left--;
      end else if (stall != 0) begin
        res_if.ready <= 1'b0;
        stall--;
      end else begin
        res_if.ready <= 1'b1;
      end
      @(negedge clk_i);
      if (res_if.valid && res_if.ready) begin
        got.status        = res_if.status;
        got.read_data     = res_if.read_data;
        got.fill_count    = res_if.fill_count;
        got.overwrite_run = res_if.overwrite_run;
        book.check_result(got);
        stall = recv_idle ? $urandom_range(0, 15) : 0;
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("decoupled_channel_fifo_top: mismatch");
        $finish;
      end
    end
  end

  initial begin : stimulus
    book         = new();
    send_idle    = 1'b1;
    recv_idle    = 1'b1;
    hold_request = 0;
    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_idx_i       <= REG_CHANNEL_KIND;
    cfg_data_i      <= '0;
    in_if.valid     <= 1'b0;
    in_if.mode      <= MODE_WRITE;
    in_if.data      <= '0;
    in_if.no_backup <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // blocking both, full length after reset
    put(MODE_READ, '0, 1'b0);
    put(MODE_WRITE, '0, 1'b0);
    put(MODE_WRITE, '1, 1'b1);
    put(MODE_READ, '0, 1'b0);
    put(MODE_READ, '0, 1'b0);

    // decoupled read: nothing kept yet, then a no_backup word, then a kept one
    set_reg(REG_CHANNEL_KIND, CFG_W'(KIND_DEC_READ));
    put(MODE_READ, '0, 1'b0);
    put(MODE_WRITE, 32'h5a5a_0ff0, 1'b1);
    put(MODE_READ, '0, 1'b0);
    put(MODE_READ, '0, 1'b0);
    put(MODE_WRITE, 32'ha5a5_f00f, 1'b0);
    put(MODE_READ, '0, 1'b0);
    put(MODE_READ, '0, 1'b0);

    // blocking, one entry: full, empty, producer gone
    set_reg(REG_CHANNEL_KIND, CFG_W'(KIND_BLOCKING));
    set_reg(REG_FIFO_LENGTH, CFG_W'(1));
    put(MODE_WRITE, 32'h0000_0001, 1'b0);
    put(MODE_WRITE, 32'h0000_0002, 1'b0);
    put(MODE_READ, '0, 1'b0);
    put(MODE_READ, '0, 1'b0);
    put(MODE_PRODUCER_GONE, '0, 1'b0);
    put(MODE_READ, '0, 1'b0);
    put(MODE_PRODUCER_GONE, '0, 1'b0);
    put(MODE_WRITE, 32'h0000_0003, 1'b1);
    put(MODE_READ, '0, 1'b0);

    // decoupled write, zero length acts as one
    set_reg(REG_CHANNEL_KIND, CFG_W'(KIND_DEC_WRITE));
    set_reg(REG_FIFO_LENGTH, '0);
    put(MODE_WRITE, 32'h0000_0004, 1'b0);
    put(MODE_WRITE, 32'h0000_0005, 1'b1);
    put(MODE_WRITE, 32'h0000_0006, 1'b0);
    put(MODE_READ, '0, 1'b0);
    put(MODE_WRITE, 32'h0000_0007, 1'b0);

    for (int p = 0; p < NUM_PHASES; p++) begin
      set_reg(REG_CHANNEL_KIND, CFG_W'(p % 4));
      set_reg(REG_FIFO_LENGTH, CFG_W'(PHASE_LEN[p]));
      send_idle = (p % 3 != 1);
      recv_idle = (p % 3 != 2);
      if (p == 5) begin
        // receiver holds off while the sender keeps offering words
        send_idle    = 1'b0;
        hold_request = HOLD_CYCLES;
      end
      random_run(PHASE_ITEMS, 1'b0);
    end

    // long overwrite run, back to back
    send_idle = 1'b0;
    recv_idle = 1'b0;
    set_reg(REG_CHANNEL_KIND, CFG_W'(KIND_DEC_WRITE));
    set_reg(REG_FIFO_LENGTH, CFG_W'(1));
    for (int k = 0; k < BURST_ITEMS; k++) begin
      send_word(pick_word(MODE_WRITE));
    end
    put(MODE_READ, '0, 1'b0);
    put(MODE_WRITE, 32'h1234_5678, 1'b0);

    // consumer side goes away after a random run; writes are dropped from then on
    send_idle = 1'b1;
    recv_idle = 1'b1;
    set_reg(REG_CHANNEL_KIND, CFG_W'(KIND_DEC_BOTH));
    set_reg(REG_FIFO_LENGTH, CFG_W'(4));
    random_run(20, 1'b0);
    put(MODE_CONSUMER_GONE, '0, 1'b0);
    random_run(40, 1'b1);
    put(MODE_CONSUMER_GONE, '0, 1'b0);
    put(MODE_READ, '0, 1'b0);

    in_if.valid <= 1'b0;
    while (book.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (book.errors == 0 && book.pending() == 0) begin
      $display("decoupled_channel_fifo_top: match");
    end else begin
      $display("decoupled_channel_fifo_top: mismatch");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* files.f */
sv/dcf_pkg.sv
sv/dcf_in_if.sv
sv/dcf_res_if.sv
sv/dcf_core.sv
sv/decoupled_channel_fifo_top.sv
bench/tb_decoupled_channel_fifo_top.sv
